### hw/rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants and types for the magic signature carver.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

    localparam int SIGNATURE_ENTRIES = 512;
    localparam int WINDOW_BYTES      = 16;
    localparam int MAGIC_MAX         = 16;
    localparam int MAGIC_MIN         = 3;

    localparam int IDX_W  = (SIGNATURE_ENTRIES > 1) ? $clog2(SIGNATURE_ENTRIES) : 1;
    localparam int POS_W  = $clog2(MAGIC_MAX);
    localparam int LEN_W  = $clog2(MAGIC_MAX + 1);
    localparam int CNT_W  = 32;

    localparam logic [1:0] CMD_LOAD_MAGIC = 2'd0;
    localparam logic [1:0] CMD_SET_LENGTH = 2'd1;
    localparam logic [1:0] CMD_DATA       = 2'd2;

    typedef logic [MAGIC_MAX-1:0][7:0]    magic_row_t;
    typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

    // table write request
    typedef struct packed {
        logic             magic_we;
        logic             len_we;
        logic [IDX_W-1:0] addr;
        logic [POS_W-1:0] pos;
        logic [7:0]       magic_data;
        logic [LEN_W-1:0] len_data;
    } tbl_wr_t;

endpackage

`default_nettype wire

### hw/rtl/msc_table.sv
// ----------------------------------------------------------------------------
// msc_table
// Signature table: magic byte rows and magic lengths, one row read per cycle while rd_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_table
    import msc_pkg::*;
(
    input  wire logic             aclk,
    input  wire tbl_wr_t          wr,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output magic_row_t            rd_row,
    output logic [LEN_W-1:0]      rd_len
);

    magic_row_t       magic_mem [SIGNATURE_ENTRIES];
    logic [LEN_W-1:0] len_mem   [SIGNATURE_ENTRIES];

    magic_row_t       rd_row_reg;
    logic [LEN_W-1:0] rd_len_reg;

    always_ff @(posedge aclk) begin
        if (wr.magic_we) begin
            magic_mem[wr.addr][wr.pos] <= wr.magic_data;
        end
        if (wr.len_we) begin
            len_mem[wr.addr] <= wr.len_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= magic_mem[rd_addr];
            rd_len_reg <= len_mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;
    assign rd_len = rd_len_reg;

endmodule

`default_nettype wire

### hw/rtl/msc_match.sv
// ----------------------------------------------------------------------------
// msc_match
// Compare unit: one table row against the leading bytes of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_match
    import msc_pkg::*;
(
    input  wire window_t          window,
    input  wire magic_row_t       row,
    input  wire logic [LEN_W-1:0] len,
    output logic                  hit
);

    logic [MAGIC_MAX-1:0] byte_ok;
    logic                 len_ok;

    always_comb begin
        for (int k = 0; k < MAGIC_MAX; k++) begin
            if (LEN_W'(k) >= len) begin
                byte_ok[k] = 1'b1;
            end else if (k < WINDOW_BYTES) begin
                byte_ok[k] = (window[k] == row[k]);
            end else begin
                byte_ok[k] = 1'b0;
            end
        end
    end

    assign len_ok = (len >= LEN_W'(MAGIC_MIN)) && ({1'b0, len} <= (LEN_W + 1)'(WINDOW_BYTES));
    assign hit    = len_ok && (&byte_ok);

endmodule

`default_nettype wire

### hw/rtl/magic_signature_carver.sv
// ----------------------------------------------------------------------------
// magic_signature_carver
// Scans a byte stream for magic signatures held in a loadable table.
//
//   channel | ports                                    | direction
//   s_      | command, entry_index, byte_position,     | in  (valid/ready)
//           | value, start_of_stream                   |
//   m_      | match_offset, signature_index,           | out (valid/ready)
//           | match_count                              |
//
// Load words leave s_ready high. A data word that arrives once the window is full
// scans the table one entry per cycle, unless a hit waits, through a single compare
// unit, ending on the first hit or the last entry; other data words leave s_ready high.
// After reset a pass over all entries clears the length table; s_ready stays low.
// A hit waits in the scan while the previous result is still held on m_.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_signature_carver
    import msc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_command,
    input  wire logic [8:0]   s_entry_index,
    input  wire logic [3:0]   s_byte_position,
    input  wire logic [7:0]   s_value,
    input  wire logic         s_start_of_stream,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [31:0]       m_match_offset,
    output logic [8:0]        m_signature_index,
    output logic [31:0]       m_match_count
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIGNATURE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  issue_reg, issue_next;
    logic              issuing_reg, issuing_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    window_t           window_reg, window_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]  found_reg, found_next;
    logic              m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]  offset_reg, offset_next;
    logic [IDX_W-1:0]  sig_reg, sig_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    tbl_wr_t           wr;
    logic              rd_en;
    magic_row_t        rd_row;
    logic [LEN_W-1:0]  rd_len;
    logic              hit;

    logic              accept;
    logic              out_free;
    logic              stall;
    logic              entry_ok;
    logic [CNT_W-1:0]  seen_base;
    logic [CNT_W-1:0]  found_base;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign stall    = pend_valid_reg && hit && !out_free;
    assign entry_ok = (int'(s_entry_index) < SIGNATURE_ENTRIES);
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        issue_next      = issue_reg;
        issuing_next    = issuing_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        window_next     = window_reg;
        seen_next       = seen_reg;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        offset_next     = offset_reg;
        sig_next        = sig_reg;
        count_next      = count_reg;
        rd_en           = 1'b0;
        seen_base       = s_start_of_stream ? '0 : seen_reg;
        found_base      = s_start_of_stream ? '0 : found_reg;

        wr.magic_we   = 1'b0;
        wr.len_we     = 1'b0;
        wr.addr       = IDX_W'(s_entry_index);
        wr.pos        = POS_W'(s_byte_position);
        wr.magic_data = s_value;
        wr.len_data   = (s_value > 8'(MAGIC_MAX)) ? LEN_W'(MAGIC_MAX) : LEN_W'(s_value);

        case (state_reg)
            ST_CLEAR: begin
                wr.len_we   = 1'b1;
                wr.addr     = clr_reg;
                wr.len_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_LOAD_MAGIC: begin
                            wr.magic_we = entry_ok;
                        end
                        CMD_SET_LENGTH: begin
                            wr.len_we = entry_ok;
                        end
                        CMD_DATA: begin
                            for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
                                window_next[k] = window_reg[k+1];
                            end
                            window_next[WINDOW_BYTES-1] = s_value;
                            seen_next  = (seen_base == CNT_MAX) ? seen_base : seen_base + 1'b1;
                            found_next = found_base;
                            if (seen_next >= CNT_W'(WINDOW_BYTES)) begin
                                state_next      = ST_SCAN;
                                issue_next      = '0;
                                issuing_next    = 1'b1;
                                pend_valid_next = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (pend_valid_reg && hit) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        found_next   = (found_reg == CNT_MAX) ? found_reg : found_reg + 1'b1;
                        count_next   = found_next;
                        offset_next  = seen_reg - CNT_W'(WINDOW_BYTES);
                        sig_next     = pend_idx_reg;
                        state_next   = ST_IDLE;
                    end
                end else if (pend_valid_reg && pend_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
                if (!stall && state_next == ST_SCAN) begin
                    // one read in flight: issue the next entry while comparing this one
                    rd_en           = issuing_reg;
                    pend_valid_next = issuing_reg;
                    pend_idx_next   = issue_reg;
                    issue_next      = issue_reg + 1'b1;
                    if (issue_reg == LAST_IDX) begin
                        issuing_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            issue_reg      <= '0;
            issuing_reg    <= 1'b0;
            pend_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            window_reg     <= '0;
            seen_reg       <= '0;
            found_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            issue_reg      <= issue_next;
            issuing_reg    <= issuing_next;
            pend_idx_reg   <= pend_idx_next;
            pend_valid_reg <= pend_valid_next;
            window_reg     <= window_next;
            seen_reg       <= seen_next;
            found_reg      <= found_next;
            m_valid_reg    <= m_valid_next;
        end
        offset_reg <= offset_next;
        sig_reg    <= sig_next;
        count_reg  <= count_next;
    end

    msc_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (issue_reg),
        .rd_row  (rd_row),
        .rd_len  (rd_len)
    );

    msc_match u_match (
        .window (window_reg),
        .row    (rd_row),
        .len    (rd_len),
        .hit    (hit)
    );

    assign m_valid           = m_valid_reg;
    assign m_match_offset    = offset_reg;
    assign m_signature_index = 9'(sig_reg);
    assign m_match_count     = count_reg;

endmodule

`default_nettype wire

### test/tb_magic_signature_carver.sv
// ----------------------------------------------------------------------------
// tb_magic_signature_carver
// Self-checking bench for the magic signature carver. Loads signature
// entries, streams data bytes that embed intact and damaged signatures among
// noise, and checks every match word against an in-bench predictor of the
// scan. Both channels idle and stall at random; one long output stall lets
// the block back up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_magic_signature_carver;
    import msc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // length of the long output stall
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int ACTIVE_MAX     = 24;

    typedef struct packed {
        logic [31:0] hit_offset;
        logic [8:0]  sig_index;
        logic [31:0] hit_count;
    } carve_hit_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [8:0]  s_entry_index = '0;
    logic [3:0]  s_byte_position = '0;
    logic [7:0]  s_value = '0;
    logic        s_start_of_stream = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_match_offset;
    logic [8:0]  m_signature_index;
    logic [31:0] m_match_count;

    magic_signature_carver uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_entry_index     (s_entry_index),
        .s_byte_position   (s_byte_position),
        .s_value           (s_value),
        .s_start_of_stream (s_start_of_stream),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_match_offset    (m_match_offset),
        .m_signature_index (m_signature_index),
        .m_match_count     (m_match_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [7:0]       sig_bytes [SIGNATURE_ENTRIES][MAGIC_MAX];
    logic [LEN_W-1:0] sig_len [SIGNATURE_ENTRIES];
    logic [7:0]       win [WINDOW_BYTES];
    logic [31:0]      stream_pos = '0;
    logic [31:0]      hits_in_stream = '0;
    carve_hit_t       expected_hits [$];

    // stimulus bookkeeping: which magic bytes have been loaded
    logic [MAGIC_MAX-1:0] sig_written [SIGNATURE_ENTRIES];
    int                   active_sigs [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic holding = 1'b0;
    event start_hold;
    int   fail_count = 0;
    int   words_sent = 0;
    int   hits_checked = 0;
    int   streams_sent = 0;
    int   quiet_cycles = 0;
    carve_hit_t got_hit;

    function automatic void carve_predict(input logic [1:0] cmd, input logic [8:0] idx,
                                          input logic [3:0] pos, input logic [7:0] val,
                                          input logic sos);
        carve_hit_t hit;
        bit         found;
        bit         same;
        int         len;
        found = 1'b0;
        case (cmd)
            CMD_LOAD_MAGIC: begin
                if (idx < SIGNATURE_ENTRIES) sig_bytes[idx][pos] = val;
            end
            CMD_SET_LENGTH: begin
                if (idx < SIGNATURE_ENTRIES)
                    sig_len[idx] = LEN_W'((val > MAGIC_MAX) ? MAGIC_MAX : int'(val));
            end
            CMD_DATA: begin
                if (sos) begin
                    stream_pos = '0;
                    hits_in_stream = '0;
                end
                for (int k = 0; k < WINDOW_BYTES - 1; k++) win[k] = win[k + 1];
                win[WINDOW_BYTES - 1] = val;
                if (stream_pos != '1) stream_pos = stream_pos + 1;
                if (stream_pos >= WINDOW_BYTES) begin
                    for (int e = 0; e < SIGNATURE_ENTRIES; e++) begin
                        len = int'(sig_len[e]);
                        if (!found && len >= MAGIC_MIN && len <= WINDOW_BYTES) begin
                            same = 1'b1;
                            for (int k = 0; k < len; k++)
                                if (win[k] != sig_bytes[e][k]) same = 1'b0;
                            if (same) begin
                                found = 1'b1;
                                if (hits_in_stream != '1) hits_in_stream = hits_in_stream + 1;
                                hit.hit_offset = stream_pos - WINDOW_BYTES;
                                hit.sig_index  = 9'(e);
                                hit.hit_count  = hits_in_stream;
                                expected_hits.push_back(hit);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [8:0] idx,
                             input logic [3:0] pos, input logic [7:0] val, input logic sos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_entry_index     <= idx;
        s_byte_position   <= pos;
        s_value           <= val;
        s_start_of_stream <= sos;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        carve_predict(cmd, idx, pos, val, sos);
        if (cmd != CMD_UNUSED) words_sent++;
    endtask

    task automatic load_byte(input logic [8:0] e, input logic [3:0] pos, input logic [7:0] b);
        sig_written[e][pos] = 1'b1;
        send_word(CMD_LOAD_MAGIC, e, pos, b, 1'($urandom_range(1)));
    endtask

    task automatic set_length(input logic [8:0] e, input logic [7:0] raw);
        send_word(CMD_SET_LENGTH, e, 4'($urandom_range(15)), raw, 1'($urandom_range(1)));
    endtask

    task automatic data_byte(input logic [7:0] b, input logic sos);
        send_word(CMD_DATA, 9'($urandom_range(511)), 4'($urandom_range(15)), b, sos);
    endtask

    task automatic mark_active(input int e);
        bit known;
        known = 1'b0;
        foreach (active_sigs[i]) if (active_sigs[i] == e) known = 1'b1;
        if (!known) active_sigs.push_back(e);
    endtask

    // Fill bytes 0..len-1 (rotated order), optionally sharing a prefix with
    // another live entry so that index order decides the winner.
    task automatic build_signature(input int e);
        int         r;
        int         raw;
        int         len;
        int         donor;
        int         rot;
        int         k;
        bit         copy;
        logic [7:0] b;
        r = $urandom_range(99);
        raw = (r < 70) ? $urandom_range(3, 8) :
              (r < 85) ? $urandom_range(9, 16) : $urandom_range(17, 255);
        len = (raw > MAGIC_MAX) ? MAGIC_MAX : raw;
        copy = (active_sigs.size() != 0) && ($urandom_range(99) < 30);
        donor = copy ? active_sigs[$urandom_range(active_sigs.size() - 1)] : 0;
        rot = $urandom_range(len - 1);
        for (int j = 0; j < len; j++) begin
            k = (j + rot) % len;
            if (copy && k < sig_len[donor]) b = sig_bytes[donor][k];
            else b = 8'($urandom_range(255));
            load_byte(9'(e), 4'(k), b);
        end
        set_length(9'(e), 8'(raw));
        mark_active(e);
    endtask

    task automatic misc_word();
        int e;
        int k;
        case ($urandom_range(3))
            0: send_word(CMD_UNUSED, 9'($urandom_range(511)), 4'($urandom_range(15)),
                         8'($urandom_range(255)), 1'($urandom_range(1)));
            1: load_byte(9'($urandom_range(511)), 4'($urandom_range(15)),
                         8'($urandom_range(255)));
            2: set_length(9'($urandom_range(511)), 8'($urandom_range(2)));
            default: begin
                // re-arm a live entry, never past its loaded prefix
                if (active_sigs.size() != 0) begin
                    e = active_sigs[$urandom_range(active_sigs.size() - 1)];
                    k = 0;
                    while (k < MAGIC_MAX && sig_written[e][k]) k++;
                    if (k >= MAGIC_MIN)
                        set_length(9'(e), (k == MAGIC_MAX) ? 8'($urandom_range(MAGIC_MIN, 255))
                                                           : 8'($urandom_range(MAGIC_MIN, k)));
                end
            end
        endcase
    endtask

    task automatic send_stream(input int n_bytes);
        int         sent;
        int         s;
        int         len;
        int         bad;
        int         r;
        bit         first;
        logic [7:0] b;
        sent = 0;
        first = 1'b1;
        streams_sent++;
        while (sent < n_bytes) begin
            r = $urandom_range(99);
            if (r < 5) begin
                misc_word();
            end else if (r < 70 && active_sigs.size() != 0) begin
                s = active_sigs[$urandom_range(active_sigs.size() - 1)];
                len = int'(sig_len[s]);
                // upper band sends a damaged copy
                bad = (r >= 58 && len > 0) ? $urandom_range(len - 1) : -1;
                for (int k = 0; k < len; k++) begin
                    b = sig_bytes[s][k];
                    if (k == bad) b = b ^ 8'($urandom_range(1, 255));
                    data_byte(b, first);
                    first = 1'b0;
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    data_byte(8'($urandom_range(255)), first || ($urandom_range(99) < 2));
                    first = 1'b0;
                    sent++;
                end
            end
        end
    endtask

    // Short entry shares the first two bytes of entry 511 but never hits;
    // the start flag on a load is ignored; command 3 is dropped.
    task automatic test_directed_match();
        load_byte(9'd511, 4'd0, 8'hFF);
        load_byte(9'd511, 4'd1, 8'h00);
        load_byte(9'd511, 4'd2, 8'hA5);
        send_word(CMD_SET_LENGTH, 9'd511, 4'd0, 8'd3, 1'b1);
        load_byte(9'd0, 4'd0, 8'hFF);
        load_byte(9'd0, 4'd1, 8'h00);
        set_length(9'd0, 8'd2);
        send_word(CMD_UNUSED, 9'd0, 4'd15, 8'hFF, 1'b1);
        data_byte(8'hFF, 1'b1);
        data_byte(8'h00, 1'b0);
        data_byte(8'hA5, 1'b0);
        repeat (12) data_byte(8'h00, 1'b0);
        data_byte(8'h80, 1'b0);
        data_byte(8'h7F, 1'b0);
        mark_active(511);
    endtask

    task automatic test_random_carving(input int n_words);
        int goal;
        goal = words_sent + n_words;
        while (words_sent < goal) begin
            if (active_sigs.size() < 4 || $urandom_range(99) < 15) begin
                if (active_sigs.size() >= ACTIVE_MAX)
                    build_signature(active_sigs[$urandom_range(active_sigs.size() - 1)]);
                else
                    build_signature($urandom_range(SIGNATURE_ENTRIES - 1));
            end else begin
                send_stream($urandom_range(16, 48));
            end
        end
    endtask

    // Repeating 3-byte magic hits every third byte while the output is held
    // off, so pending hits back up and the input stalls.
    task automatic test_output_backpressure();
        load_byte(9'd2, 4'd0, 8'h3C);
        load_byte(9'd2, 4'd1, 8'hC3);
        load_byte(9'd2, 4'd2, 8'h7E);
        set_length(9'd2, 8'd3);
        mark_active(2);
        -> start_hold;
        streams_sent++;
        for (int i = 0; i < 20; i++) begin
            data_byte(8'h3C, i == 0);
            data_byte(8'hC3, 1'b0);
            data_byte(8'h7E, 1'b0);
        end
    endtask

    always begin
        @(start_hold);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding <= 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_hits.size() == 0) begin
                $error("match word with none pending: offset %0d entry %0d count %0d",
                       m_match_offset, m_signature_index, m_match_count);
                fail_count++;
            end else begin
                got_hit = expected_hits.pop_front();
                hits_checked++;
                if (m_match_offset !== got_hit.hit_offset) begin
                    $error("match_offset: expected %0d, got %0d",
                           got_hit.hit_offset, m_match_offset);
                    fail_count++;
                end
                if (m_signature_index !== got_hit.sig_index) begin
                    $error("signature_index: expected %0d, got %0d",
                           got_hit.sig_index, m_signature_index);
                    fail_count++;
                end
                if (m_match_count !== got_hit.hit_count) begin
                    $error("match_count: expected %0d, got %0d",
                           got_hit.hit_count, m_match_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d hits pending",
                     quiet_cycles, expected_hits.size());
            $display("tb_magic_signature_carver failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int e = 0; e < SIGNATURE_ENTRIES; e++) begin
            sig_len[e] = '0;
            sig_written[e] = '0;
        end
        for (int k = 0; k < WINDOW_BYTES; k++) win[k] = '0;
        send_idle_pct = 25;
        recv_idle_pct = 80;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_match();
        test_random_carving(250);
        send_idle_pct = 80;
        recv_idle_pct = 25;
        test_output_backpressure();
        test_random_carving(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_carving(250);
        s_valid <= 1'b0;

        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d words in %0d streams, %0d signatures live at the end",
                 words_sent, streams_sent, active_sigs.size());
        $display("checked %0d match words, including a %0d-cycle output stall",
                 hits_checked, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("tb_magic_signature_carver passed");
        end else begin
            $display("tb_magic_signature_carver failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
